FILE: src/fsam_pkg.sv
// ----------------------------------------------------------------------------
// fsam_pkg
// Shared types, constants and helpers for the fingertip outline alpha mask.
// ----------------------------------------------------------------------------
package fsam_pkg;

    localparam int EXT_W      = 10;
    localparam int X_W        = 11;
    localparam int Y_W        = 12;
    localparam int ALPHA_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 2 * EXT_W;
    localparam int R2_W       = 2 * PROD_W;
    localparam int QUO_W      = 32;
    localparam int ROOT_W     = QUO_W / 2;
    localparam int BAND_N_W   = 29;
    localparam int BAND_Q_W   = 15;
    localparam int SQ_STAGES  = ROOT_W;

    localparam logic [EXT_W-1:0] MAX_EXTENT = 10'd1023;
    localparam logic [EXT_W-1:0] EXT_RESET  = 10'd128;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'd32768;
    localparam logic [BAND_N_W-1:0] BAND_SCALE = 29'd409600;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd4;

    typedef enum logic [1:0] {
        FIN_ZERO,
        FIN_ONE,
        FIN_ELL,
        FIN_BAND
    } fin_code_t;

    function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
        clamp_extent = (v > MAX_EXTENT) ? MAX_EXTENT : v;
    endfunction

endpackage

FILE: src/fingertip_shape_alpha_mask_unit.sv
// ----------------------------------------------------------------------------
// fingertip_shape_alpha_mask_unit
// Coverage alpha (Q1.15) of a fingertip outline for one pixel per transfer.
// ----------------------------------------------------------------------------
// One pixel is taken every cycle while in_stall is low. A 32-stage
// restoring divider (normalised radius and band ramp share it) is followed
// by the 16-stage square root. An output register with a skid stage keeps
// input transfers going while a result waits; in_stall rises only while
// the skid stage is occupied. Extents must be written only while no pixel
// is in flight; the block itself does not enforce this.
module fingertip_shape_alpha_mask_unit
    import fsam_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EXT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [X_W-1:0]       pixel_x,
    input  logic [Y_W-1:0]       pixel_y,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ALPHA_W-1:0]   alpha,
    output logic                 in_range
);

    logic [EXT_W-1:0] left_reg, right_reg, top_reg, middle_reg, bottom_reg;
    logic [EXT_W-1:0] ext_l, ext_r, ext_t, ext_m, ext_b;
    logic             en;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= EXT_RESET;
            right_reg  <= EXT_RESET;
            top_reg    <= EXT_RESET;
            middle_reg <= EXT_RESET;
            bottom_reg <= EXT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LEFT:   left_reg   <= cfg_data;
                REG_RIGHT:  right_reg  <= cfg_data;
                REG_TOP:    top_reg    <= cfg_data;
                REG_MIDDLE: middle_reg <= cfg_data;
                REG_BOTTOM: bottom_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign ext_l = clamp_extent(left_reg);
    assign ext_r = clamp_extent(right_reg);
    assign ext_t = clamp_extent(top_reg);
    assign ext_m = clamp_extent(middle_reg);
    assign ext_b = clamp_extent(bottom_reg);

    // stage 1: geometry
    logic [X_W-1:0]   w_c, wm1x_c;
    logic [Y_W-1:0]   h_c;
    logic [X_W-1:0]   tm_c;
    logic             top_c, bot_c, inr_c;
    logic [EXT_W-1:0] adx_c, ady_c, ax_c, ay_c, d_c, m_c;
    logic [Y_W-1:0]   dy_full_c;

    always_comb
    begin
        w_c    = {1'b0, ext_l} + {1'b0, ext_r};
        h_c    = {2'b0, ext_t} + {2'b0, ext_m} + {2'b0, ext_b};
        tm_c   = {1'b0, ext_t} + {1'b0, ext_m};
        inr_c  = (pixel_x < w_c) && (pixel_y < h_c);
        top_c  = pixel_y < {2'b0, ext_t};
        bot_c  = pixel_y > {1'b0, tm_c};
        if (top_c)
        begin
            dy_full_c = {2'b0, ext_t} - pixel_y;
            ay_c      = ext_t;
        end
        else
        begin
            dy_full_c = pixel_y - {1'b0, tm_c};
            ay_c      = ext_b;
        end
        ady_c = dy_full_c[EXT_W-1:0];
        if (pixel_x <= {1'b0, ext_l})
        begin
            adx_c = ext_l - pixel_x[EXT_W-1:0];
            ax_c  = ext_l;
        end
        else
        begin
            adx_c = pixel_x[EXT_W-1:0] - ext_l;
            ax_c  = ext_r;
        end
        wm1x_c = w_c - 11'd1 - pixel_x;
        d_c    = (pixel_x < wm1x_c) ? pixel_x[EXT_W-1:0] : wm1x_c[EXT_W-1:0];
        m_c    = (ext_l < ext_r) ? ext_l : ext_r;
    end

    logic             s1_valid_reg;
    logic             s1_inr_reg, s1_band_reg;
    logic [EXT_W-1:0] s1_adx_reg, s1_ady_reg, s1_ax_reg, s1_ay_reg, s1_d_reg, s1_m_reg;

    // stage 2: squares, band numerator
    logic              s2_valid_reg, s2_inr_reg, s2_band_reg, s2_mz_reg, s2_cap_reg;
    logic [PROD_W-1:0] s2_adx2_reg, s2_ady2_reg, s2_ax2_reg, s2_ay2_reg;
    logic [BAND_N_W-1:0] s2_n_reg;

    // stage 3: cross products
    logic              s3_valid_reg, s3_inr_reg, s3_band_reg, s3_mz_reg, s3_cap_reg;
    logic [R2_W-1:0]   s3_p1_reg, s3_p2_reg, s3_den_reg;
    logic [BAND_N_W-1:0] s3_n_reg;
    logic [EXT_W-1:0]  s2_m_reg, s3_m_reg, s4_m_reg;

    // stage 4: radius sum
    logic              s4_valid_reg, s4_inr_reg, s4_band_reg, s4_mz_reg, s4_cap_reg;
    logic [R2_W:0]     s4_r2_reg;
    logic [R2_W-1:0]   s4_den_reg;
    logic [BAND_N_W-1:0] s4_n_reg;

    // stage 5: classify and load divider
    logic              ge_c, one_c;
    fin_code_t         code_c;
    logic [R2_W-1:0]   rem0_c, dsr0_c;
    logic [QUO_W-1:0]  ext0_c;

    always_comb
    begin
        ge_c  = s4_r2_reg >= {1'b0, s4_den_reg};
        one_c = ({10'd0, s4_r2_reg} * 51'd625) < ({11'd0, s4_den_reg} * 51'd529);
        if (!s4_inr_reg)
            code_c = FIN_ZERO;
        else if (s4_band_reg)
            code_c = (s4_mz_reg || s4_cap_reg) ? FIN_ONE : FIN_BAND;
        else if (ge_c)
            code_c = FIN_ZERO;
        else if (one_c)
            code_c = FIN_ONE;
        else
            code_c = FIN_ELL;
        if (s4_band_reg)
        begin
            rem0_c = {{(R2_W-BAND_N_W+BAND_Q_W){1'b0}}, s4_n_reg[BAND_N_W-1:BAND_Q_W]};
            dsr0_c = {{(R2_W-EXT_W){1'b0}}, s4_m_reg};
            ext0_c = {s4_n_reg[BAND_Q_W-1:0], {(QUO_W-BAND_Q_W){1'b0}}};
        end
        else
        begin
            rem0_c = s4_r2_reg[R2_W-1:0];
            dsr0_c = s4_den_reg;
            ext0_c = '0;
        end
    end

    logic              dv_valid_reg [0:QUO_W];
    logic              dv_inr_reg   [0:QUO_W];
    fin_code_t         dv_code_reg  [0:QUO_W];
    logic [R2_W-1:0]   dv_rem_reg   [0:QUO_W];
    logic [R2_W-1:0]   dv_dsr_reg   [0:QUO_W];
    logic [QUO_W-1:0]  dv_ext_reg   [0:QUO_W];
    logic [QUO_W-1:0]  dv_q_reg     [0:QUO_W];

    logic [R2_W:0]     dv_t_c   [0:QUO_W-1];
    logic              dv_ge_c  [0:QUO_W-1];
    logic [R2_W:0]     dv_sub_c [0:QUO_W-1];

    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            dv_t_c[k]   = {dv_rem_reg[k], dv_ext_reg[k][QUO_W-1]};
            dv_ge_c[k]  = dv_t_c[k] >= {1'b0, dv_dsr_reg[k]};
            dv_sub_c[k] = dv_t_c[k] - {1'b0, dv_dsr_reg[k]};
        end
    end

    // square root
    logic              sq_valid_reg [0:SQ_STAGES];
    logic              sq_inr_reg   [0:SQ_STAGES];
    fin_code_t         sq_code_reg  [0:SQ_STAGES];
    logic [BAND_Q_W-1:0] sq_bq_reg  [0:SQ_STAGES];
    logic [QUO_W-1:0]  sq_rad_reg   [0:SQ_STAGES];
    logic [ROOT_W:0]   sq_rem_reg   [0:SQ_STAGES];
    logic [ROOT_W-1:0] sq_root_reg  [0:SQ_STAGES];

    logic [ROOT_W+2:0] sq_rm_c  [0:SQ_STAGES-1];
    logic [ROOT_W+2:0] sq_t_c   [0:SQ_STAGES-1];
    logic              sq_ge_c  [0:SQ_STAGES-1];
    logic [ROOT_W+2:0] sq_sub_c [0:SQ_STAGES-1];

    always_comb
    begin
        for (int j = 0; j < SQ_STAGES; j++)
        begin
            sq_rm_c[j]  = {sq_rem_reg[j], sq_rad_reg[j][QUO_W-1:QUO_W-2]};
            sq_t_c[j]   = {1'b0, sq_root_reg[j], 2'b01};
            sq_ge_c[j]  = sq_rm_c[j] >= sq_t_c[j];
            sq_sub_c[j] = sq_rm_c[j] - sq_t_c[j];
        end
    end

    // control: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            for (int k = 0; k <= QUO_W; k++)
                dv_valid_reg[k] <= 1'b0;
            for (int j = 0; j <= SQ_STAGES; j++)
                sq_valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg    <= in_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            dv_valid_reg[0] <= s4_valid_reg;
            for (int k = 0; k < QUO_W; k++)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            sq_valid_reg[0] <= dv_valid_reg[QUO_W];
            for (int j = 0; j < SQ_STAGES; j++)
                sq_valid_reg[j+1] <= sq_valid_reg[j];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_inr_reg  <= inr_c;
            s1_band_reg <= !top_c && !bot_c;
            s1_adx_reg  <= adx_c;
            s1_ady_reg  <= ady_c;
            s1_ax_reg   <= ax_c;
            s1_ay_reg   <= ay_c;
            s1_d_reg    <= d_c;
            s1_m_reg    <= m_c;

            s2_inr_reg  <= s1_inr_reg;
            s2_band_reg <= s1_band_reg;
            s2_adx2_reg <= {{EXT_W{1'b0}}, s1_adx_reg} * {{EXT_W{1'b0}}, s1_adx_reg};
            s2_ady2_reg <= {{EXT_W{1'b0}}, s1_ady_reg} * {{EXT_W{1'b0}}, s1_ady_reg};
            s2_ax2_reg  <= {{EXT_W{1'b0}}, s1_ax_reg} * {{EXT_W{1'b0}}, s1_ax_reg};
            s2_ay2_reg  <= {{EXT_W{1'b0}}, s1_ay_reg} * {{EXT_W{1'b0}}, s1_ay_reg};
            s2_n_reg    <= {{(BAND_N_W-EXT_W){1'b0}}, s1_d_reg} * BAND_SCALE;
            s2_cap_reg  <= ({5'd0, s1_d_reg} * 15'd25) >= {4'd0, s1_m_reg, 1'b0};
            s2_mz_reg   <= s1_m_reg == '0;
            s2_m_reg    <= s1_m_reg;

            s3_inr_reg  <= s2_inr_reg;
            s3_band_reg <= s2_band_reg;
            s3_mz_reg   <= s2_mz_reg;
            s3_cap_reg  <= s2_cap_reg;
            s3_p1_reg   <= {{PROD_W{1'b0}}, s2_adx2_reg} * {{PROD_W{1'b0}}, s2_ay2_reg};
            s3_p2_reg   <= {{PROD_W{1'b0}}, s2_ady2_reg} * {{PROD_W{1'b0}}, s2_ax2_reg};
            s3_den_reg  <= {{PROD_W{1'b0}}, s2_ax2_reg} * {{PROD_W{1'b0}}, s2_ay2_reg};
            s3_n_reg    <= s2_n_reg;
            s3_m_reg    <= s2_m_reg;

            s4_inr_reg  <= s3_inr_reg;
            s4_band_reg <= s3_band_reg;
            s4_mz_reg   <= s3_mz_reg;
            s4_cap_reg  <= s3_cap_reg;
            s4_r2_reg   <= {1'b0, s3_p1_reg} + {1'b0, s3_p2_reg};
            s4_den_reg  <= s3_den_reg;
            s4_n_reg    <= s3_n_reg;
            s4_m_reg    <= s3_m_reg;

            dv_inr_reg[0]  <= s4_inr_reg;
            dv_code_reg[0] <= code_c;
            dv_rem_reg[0]  <= rem0_c;
            dv_dsr_reg[0]  <= dsr0_c;
            dv_ext_reg[0]  <= ext0_c;
            dv_q_reg[0]    <= '0;
            for (int k = 0; k < QUO_W; k++)
            begin
                dv_inr_reg[k+1]  <= dv_inr_reg[k];
                dv_code_reg[k+1] <= dv_code_reg[k];
                dv_dsr_reg[k+1]  <= dv_dsr_reg[k];
                dv_ext_reg[k+1]  <= {dv_ext_reg[k][QUO_W-2:0], 1'b0};
                dv_q_reg[k+1]    <= {dv_q_reg[k][QUO_W-2:0], dv_ge_c[k]};
                dv_rem_reg[k+1]  <= dv_ge_c[k] ? dv_sub_c[k][R2_W-1:0]
                                               : dv_t_c[k][R2_W-1:0];
            end

            sq_inr_reg[0]  <= dv_inr_reg[QUO_W];
            sq_code_reg[0] <= dv_code_reg[QUO_W];
            sq_bq_reg[0]   <= dv_q_reg[QUO_W][QUO_W-1:QUO_W-BAND_Q_W];
            sq_rad_reg[0]  <= dv_q_reg[QUO_W];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int j = 0; j < SQ_STAGES; j++)
            begin
                sq_inr_reg[j+1]  <= sq_inr_reg[j];
                sq_code_reg[j+1] <= sq_code_reg[j];
                sq_bq_reg[j+1]   <= sq_bq_reg[j];
                sq_rad_reg[j+1]  <= {sq_rad_reg[j][QUO_W-3:0], 2'b00};
                sq_root_reg[j+1] <= {sq_root_reg[j][ROOT_W-2:0], sq_ge_c[j]};
                sq_rem_reg[j+1]  <= sq_ge_c[j] ? sq_sub_c[j][ROOT_W:0]
                                               : sq_rm_c[j][ROOT_W:0];
            end
        end
    end

    // final alpha
    logic [ROOT_W:0]    vdiff_c;
    logic [ROOT_W+5:0]  vprod_c;
    logic [ALPHA_W-1:0] alpha_c;

    always_comb
    begin
        vdiff_c = 17'd65536 - {1'b0, sq_root_reg[SQ_STAGES]};
        vprod_c = {5'd0, vdiff_c} * 22'd25;
        unique case (sq_code_reg[SQ_STAGES])
            FIN_ZERO: alpha_c = '0;
            FIN_ONE:  alpha_c = ALPHA_ONE;
            FIN_ELL:  alpha_c = (vprod_c[ROOT_W+5:2] > {4'd0, ALPHA_ONE})
                                ? ALPHA_ONE : vprod_c[ALPHA_W+1:2];
            FIN_BAND: alpha_c = {1'b0, sq_bq_reg[SQ_STAGES]};
            default:  alpha_c = '0;
        endcase
    end

    // output register and skid stage
    logic               out_valid_reg, skid_valid_reg;
    logic [ALPHA_W-1:0] out_alpha_reg, skid_alpha_reg;
    logic               out_inr_reg, skid_inr_reg;
    logic               out_load;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign out_load = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_load)
            out_valid_reg <= sq_valid_reg[SQ_STAGES];
        else if (sq_valid_reg[SQ_STAGES])
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_load)
            begin
                out_alpha_reg <= skid_alpha_reg;
                out_inr_reg   <= skid_inr_reg;
            end
        end
        else if (out_load)
        begin
            out_alpha_reg <= alpha_c;
            out_inr_reg   <= sq_inr_reg[SQ_STAGES];
        end
        else
        begin
            skid_alpha_reg <= alpha_c;
            skid_inr_reg   <= sq_inr_reg[SQ_STAGES];
        end
    end

    assign out_valid = out_valid_reg;
    assign alpha     = out_alpha_reg;
    assign in_range  = out_inr_reg;

endmodule

FILE: test/fingertip_shape_alpha_mask_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fingertip_shape_alpha_mask_unit_tb
// Self-checking bench for the fingertip outline alpha mask. Pixels are sent
// under several extent settings; an in-bench coverage predictor computes the
// expected alpha and range flag for each accepted pixel, and every result
// transfer is compared in order against it.
// ----------------------------------------------------------------------------
module fingertip_shape_alpha_mask_unit_tb;
    import fsam_pkg::*;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               in_range;
    } coverage_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [EXT_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [X_W-1:0]       pixel_x;
    logic [Y_W-1:0]       pixel_y;
    logic                 out_valid;
    logic                 out_stall;
    logic [ALPHA_W-1:0]   alpha;
    logic                 in_range;

    coverage_t   pending_cov[$];
    logic [9:0]  ext_l, ext_r, ext_t, ext_m, ext_b;
    int          errors;
    int          pixels_sent;
    int          results_seen;
    int          cycle_count;
    bit          sink_idle_on;
    bit          src_idle_on;
    int          hold_off;

    fingertip_shape_alpha_mask_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .alpha     (alpha),
        .in_range  (in_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] ellipse_cov(input logic [63:0] x, input logic [63:0] y,
                                                input logic [63:0] cx, input logic [63:0] cy,
                                                input logic [63:0] ay);
        logic [63:0] adx, ady, ax, r2, den, q, rem, vq, a;
        if (x <= cx)
        begin
            adx = cx - x;
            ax  = ext_l;
        end
        else
        begin
            adx = x - cx;
            ax  = ext_r;
        end
        ady = (y >= cy) ? y - cy : cy - y;
        r2  = adx * adx * ay * ay + ady * ady * ax * ax;
        den = ax * ax * ay * ay;
        if (r2 >= den)
            return 16'd0;
        if (r2 * 625 < den * 529)
            return ALPHA_ONE;
        q   = 0;
        rem = r2;
        for (int i = 0; i < 32; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den)
            begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        vq = int_sqrt(q);
        if (vq >= 65536)
            return 16'd0;
        a = ((65536 - vq) * 25) >> 2;
        return (a > ALPHA_ONE) ? ALPHA_ONE : a[15:0];
    endfunction

    function automatic coverage_t predict_coverage(input logic [X_W-1:0] px,
                                                   input logic [Y_W-1:0] py);
        coverage_t   c;
        logic [63:0] x, y, w, h, m, d, a;
        x = px;
        y = py;
        w = ext_l + ext_r;
        h = ext_t + ext_m + ext_b;
        c.in_range = 1'b1;
        if (x >= w || y >= h)
        begin
            c.alpha    = 0;
            c.in_range = 1'b0;
        end
        else if (y < ext_t)
            c.alpha = ellipse_cov(x, y, ext_l, ext_t, ext_t);
        else if (y > ext_t + ext_m)
            c.alpha = ellipse_cov(x, y, ext_l, ext_t + ext_m, ext_b);
        else
        begin
            m = (ext_l < ext_r) ? ext_l : ext_r;
            d = (x < w - 1 - x) ? x : w - 1 - x;
            if (m == 0)
                c.alpha = ALPHA_ONE;
            else
            begin
                a = (d * 25 * 32768) / (m * 2);
                c.alpha = (a > ALPHA_ONE) ? ALPHA_ONE : a[15:0];
            end
        end
        return c;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sink: random stall, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off  <= hold_off - 1;
        end
        else
            out_stall <= sink_idle_on ? ($urandom_range(99) < 22) : 1'b0;
    end

    always @(posedge clk)
    begin
        coverage_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (pending_cov.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result alpha=%0d in_range=%0b",
                         $time, alpha, in_range);
            end
            else
            begin
                want = pending_cov.pop_front();
                if (alpha !== want.alpha)
                begin
                    errors++;
                    $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, alpha);
                end
                if (in_range !== want.in_range)
                begin
                    errors++;
                    $display("%0t: in_range expected %0b actual %0b",
                             $time, want.in_range, in_range);
                end
            end
        end
    end

    task automatic send_pixel(input logic [X_W-1:0] px, input logic [Y_W-1:0] py);
        while (src_idle_on && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= px;
        pixel_y  <= py;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_cov.push_back(predict_coverage(px, py));
        pixels_sent++;
    endtask

    task automatic drain_pipe();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (pending_cov.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_extent(input logic [CFG_IDX_W-1:0] idx, input logic [EXT_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_LEFT:   ext_l = v;
            REG_RIGHT:  ext_r = v;
            REG_TOP:    ext_t = v;
            REG_MIDDLE: ext_m = v;
            REG_BOTTOM: ext_b = v;
            default:    ;
        endcase
    endtask

    task automatic set_shape(input logic [9:0] l, input logic [9:0] r, input logic [9:0] t,
                             input logic [9:0] m, input logic [9:0] b);
        write_extent(REG_LEFT, l);
        write_extent(REG_RIGHT, r);
        write_extent(REG_TOP, t);
        write_extent(REG_MIDDLE, m);
        write_extent(REG_BOTTOM, b);
    endtask

    task automatic random_pixels(input int count);
        int w, h;
        w = ext_l + ext_r;
        h = ext_t + ext_m + ext_b;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 8)
                send_pixel($urandom_range(w + 1), $urandom_range(h + 1));
            else
                send_pixel($urandom_range(2047), $urandom_range(4095));
        end
    endtask

    task automatic test_directed();
        send_pixel(0, 0);
        send_pixel(128, 0);
        send_pixel(128, 128);
        send_pixel(128, 200);
        send_pixel(0, 200);
        send_pixel(255, 200);
        send_pixel(5, 200);
        send_pixel(128, 383);
        send_pixel(20, 60);
        send_pixel(240, 330);
        send_pixel(256, 10);
        send_pixel(10, 384);
        send_pixel(2047, 4095);
        send_pixel(1024, 2048);
        send_pixel(128, 6);
        send_pixel(118, 3);
        drain_pipe();
        write_extent(3'd7, 10'h3FF);
        write_extent(3'd5, 10'd1);
        send_pixel(100, 100);
        drain_pipe();
    endtask

    task automatic test_zero_extents();
        set_shape(1, 0, 0, 4, 0);
        send_pixel(0, 0);
        send_pixel(0, 2);
        send_pixel(1, 2);
        drain_pipe();
        set_shape(0, 1, 3, 0, 2);
        send_pixel(0, 1);
        send_pixel(0, 3);
        send_pixel(0, 4);
        drain_pipe();
        set_shape(5, 0, 4, 4, 4);
        random_pixels(20);
        drain_pipe();
    endtask

    task automatic test_max_extents();
        set_shape(1023, 1023, 1023, 1023, 1023);
        send_pixel(2045, 3068);
        send_pixel(0, 3068);
        send_pixel(2045, 0);
        send_pixel(1023, 1023);
        send_pixel(1023, 2046);
        random_pixels(40);
        drain_pipe();
    endtask

    task automatic test_random_shapes();
        for (int k = 0; k < 8; k++)
        begin
            set_shape($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(300),
                      $urandom_range(300), $urandom_range(300));
            sink_idle_on = (k != 3);
            src_idle_on  = (k != 3);
            random_pixels(70);
            drain_pipe();
        end
        sink_idle_on = 1'b1;
        src_idle_on  = 1'b1;
    endtask

    task automatic test_backpressure();
        set_shape(40, 60, 30, 20, 50);
        src_idle_on = 1'b0;
        @(posedge clk);
        hold_off = 200;
        random_pixels(100);
        src_idle_on = 1'b1;
        drain_pipe();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel_x      = '0;
        pixel_y      = '0;
        out_stall    = 1'b0;
        errors       = 0;
        pixels_sent  = 0;
        results_seen = 0;
        cycle_count  = 0;
        hold_off     = 0;
        sink_idle_on = 1'b1;
        src_idle_on  = 1'b1;
        ext_l = EXT_RESET;
        ext_r = EXT_RESET;
        ext_t = EXT_RESET;
        ext_m = EXT_RESET;
        ext_b = EXT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_zero_extents();
        test_max_extents();
        test_random_shapes();
        test_backpressure();
        if (pending_cov.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results missing", $time, pending_cov.size());
        end
        $display("Sent %0d pixels over reset, zero, maximum and random extents,", pixels_sent);
        $display("checked %0d results with random stalls and a long output hold-off.",
                 results_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
src/fsam_pkg.sv
src/fingertip_shape_alpha_mask_unit.sv
test/fingertip_shape_alpha_mask_unit_tb.sv
